// ===== design/chunk_reorder_receiver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHUNK_REORDER_RECEIVER_UNIT_ASSERT_SVH
`define CHUNK_REORDER_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define CRR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/crr_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver package
// Field types, codes, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
package crr_pkg;

   localparam int TRANSFERS_DEFAULT = 8;
   localparam int WINDOW_DEFAULT    = 16;
   localparam int MAX_RESULTS       = 16;
   localparam int ACK_DEPTH         = 3;
   localparam int RCNT_W            = $clog2(MAX_RESULTS + 1);

   typedef logic [2:0]  tid_type;
   typedef logic [15:0] seq_type;
   typedef logic [8:0]  clen_type;
   typedef logic [47:0] offset_type;
   typedef logic [3:0]  dslot_type;
   typedef logic [1:0]  status_type;
   typedef logic [1:0]  ackcnt_type;

   localparam logic CMD_OPEN = 1'b0;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_UNKNOWN = 2'd1;
   localparam status_type STATUS_EMPTY   = 2'd2;
   localparam status_type STATUS_AHEAD   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CTX,
      ST_CHECK,
      ST_REL,
      ST_ONE,
      ST_WB
   } crr_state_type;

   typedef struct packed {
      status_type status;
      logic       deliver_valid;
      seq_type    deliver_seq;
      dslot_type  deliver_slot;
      offset_type deliver_offset;
      clen_type   deliver_length;
      ackcnt_type ack_count;
      seq_type    ack_newest;
      seq_type    ack_middle;
      seq_type    ack_oldest;
      logic       last;
   } crr_result_type;

endpackage

// ===== design/crr_ifs.sv =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface crr_req_if;
   import crr_pkg::*;

   logic     valid;
   logic     ready;
   logic     command;
   tid_type  xfer_id;
   seq_type  seq_id;
   clen_type chunk_length;

   modport source (output valid, output command, output xfer_id, output seq_id,
                   output chunk_length, input ready);
   modport sink (input valid, input command, input xfer_id, input seq_id,
                 input chunk_length, output ready);
endinterface

interface crr_rsp_if;
   import crr_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic       deliver_valid;
   seq_type    deliver_seq;
   dslot_type  deliver_slot;
   offset_type deliver_offset;
   clen_type   deliver_length;
   ackcnt_type ack_count;
   seq_type    ack_newest;
   seq_type    ack_middle;
   seq_type    ack_oldest;
   logic       last;

   modport source (output valid, output status, output deliver_valid, output deliver_seq,
                   output deliver_slot, output deliver_offset, output deliver_length,
                   output ack_count, output ack_newest, output ack_middle,
                   output ack_oldest, output last, input ready);
   modport sink (input valid, input status, input deliver_valid, input deliver_seq,
                 input deliver_slot, input deliver_offset, input deliver_length,
                 input ack_count, input ack_newest, input ack_middle,
                 input ack_oldest, input last, output ready);
endinterface

// ===== design/chunk_reorder_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver unit
// Receive-side reorder controller: stores chunk lengths per window slot and
// releases contiguous chunks in order with byte offsets and ack history.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word that yields a single result (error or
// unknown transfer) reads the transfer context and then emits that result; an
// open also writes the context back; a data word that releases nothing checks
// the head slot too. A data word that releases N chunks (N up to 16) reads the
// transfer context from the context RAM, checks the head slot, streams one
// result per cycle from the slot-length RAM while rsp_chan.ready stays high,
// then writes the context back, and only then takes a new word. Results sit in
// an output register, so the next word's processing overlaps a waiting result.
// After reset every transfer is closed; no initialization pass is needed.
`include "chunk_reorder_receiver_unit_assert.svh"

module chunk_reorder_receiver_unit #(
   parameter int TRANSFERS = crr_pkg::TRANSFERS_DEFAULT,
   parameter int WINDOW    = crr_pkg::WINDOW_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   crr_req_if.sink   req_chan,
   crr_rsp_if.source rsp_chan
);
   import crr_pkg::*;

   logic           out_free;
   logic           res_load;
   crr_result_type res_data;
   logic           rsp_valid_ff, rsp_valid_in;
   crr_result_type rsp_data_ff, rsp_data_in;

   crr_engine #(.TRANSFERS(TRANSFERS), .WINDOW(WINDOW)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .res_load (res_load),
      .res_data (res_data)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = res_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
      rsp_data_in  = res_load ? res_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.deliver_valid  = rsp_data_ff.deliver_valid;
   assign rsp_chan.deliver_seq    = rsp_data_ff.deliver_seq;
   assign rsp_chan.deliver_slot   = rsp_data_ff.deliver_slot;
   assign rsp_chan.deliver_offset = rsp_data_ff.deliver_offset;
   assign rsp_chan.deliver_length = rsp_data_ff.deliver_length;
   assign rsp_chan.ack_count      = rsp_data_ff.ack_count;
   assign rsp_chan.ack_newest     = rsp_data_ff.ack_newest;
   assign rsp_chan.ack_middle     = rsp_data_ff.ack_middle;
   assign rsp_chan.ack_oldest     = rsp_data_ff.ack_oldest;
   assign rsp_chan.last           = rsp_data_ff.last;

   `CRR_ASSERT_IMPLY(a_load_into_free, res_load, !rsp_valid_ff || rsp_chan.ready, "result overwrites a waiting word")
   `CRR_ASSERT_IMPLY(a_error_single, rsp_valid_ff && rsp_data_ff.status != STATUS_OK, rsp_data_ff.last && !rsp_data_ff.deliver_valid && rsp_data_ff.ack_count == '0, "error result is not a bare final word")
   `CRR_ASSERT_IMPLY(a_no_delivery_zero, rsp_valid_ff && !rsp_data_ff.deliver_valid, rsp_data_ff.deliver_offset == '0 && rsp_data_ff.deliver_seq == '0 && rsp_data_ff.deliver_length == '0, "delivery fields set without a delivery")
   `CRR_ASSERT_NEXT(a_one_word_at_a_time, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while a word is in work")

endmodule

// ===== design/crr_ram.sv =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crr_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/crr_engine.sv =====
// ----------------------------------------------------------------------------
// Chunk reorder receiver engine
// Per-transfer context RAM and slot-length RAM with the sequencer that reads
// one transfer context per word and writes it back after an open or accepted chunk.
// ----------------------------------------------------------------------------
module crr_engine #(
   parameter int TRANSFERS = crr_pkg::TRANSFERS_DEFAULT,
   parameter int WINDOW    = crr_pkg::WINDOW_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   crr_req_if.sink                 req_chan,
   input  logic                    out_free,
   output logic                    res_load,
   output crr_pkg::crr_result_type res_data
);
   import crr_pkg::*;

   localparam int TW        = (TRANSFERS > 1) ? $clog2(TRANSFERS) : 1;
   localparam int SW        = $clog2(WINDOW);
   localparam int SW1       = SW + 1;
   localparam int LAW       = TW + SW;
   localparam int LEN_DEPTH = 2 ** LAW;
   localparam int CLEN_W    = $bits(clen_type);
   // context word: expected seq, expected slot, bytes, full bits, ack history, ack fill
   localparam int CTX_W     = 16 + SW + 48 + WINDOW + 48 + 2;

   crr_state_type state_ff, state_in;

   // captured request word
   logic       cmd_ff;
   tid_type    tid_ff;
   seq_type    seq_ff;
   clen_type   len_ff;

   // working copy of the context
   seq_type          w_exp_ff, w_exp_in;
   logic [SW-1:0]    w_slot_ff, w_slot_in;
   offset_type       w_bytes_ff, w_bytes_in;
   logic [WINDOW-1:0] w_full_ff, w_full_in;
   logic [47:0]      w_ack_ff, w_ack_in;
   ackcnt_type       w_fill_ff, w_fill_in;
   logic [RCNT_W-1:0] k_ff, k_in;
   status_type       status_ff, status_in;
   logic             ack_en_ff, ack_en_in;
   logic             wb_ff, wb_in;

   logic [TRANSFERS-1:0] ctx_valid_ff;

   logic              accept;
   logic [TW-1:0]     tidx;
   logic              tid_known;
   logic              c_valid;

   logic              ctx_rd_en, ctx_wr_en;
   logic [CTX_W-1:0]  ctx_rd_data, ctx_wr_data;
   logic              len_wr_en, len_rd_en;
   logic [LAW-1:0]    len_wr_addr, len_rd_addr;
   clen_type          len_rd_data;

   seq_type           r_exp, c_exp;
   logic [SW-1:0]     r_slot, c_slot;
   offset_type        r_bytes, c_bytes;
   logic [WINDOW-1:0] r_full, c_full;
   logic [47:0]       r_ack, c_ack;
   ackcnt_type        r_fill, c_fill;

   seq_type           seq_dist;
   logic              in_win, old_dup;
   logic [SW1-1:0]    slot_sum;
   logic [SW-1:0]     new_slot;

   logic [SW-1:0]     nxt_slot;
   logic [WINDOW-1:0] nxt_full;
   logic              more;
   logic [48:0]       bytes_sum;
   offset_type        bytes_sat;

   crr_ram #(.WIDTH(CTX_W), .DEPTH(TRANSFERS)) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ctx_wr_en),
      .wr_addr (tidx),
      .wr_data (ctx_wr_data),
      .rd_en   (ctx_rd_en),
      .rd_addr (TW'(req_chan.xfer_id)),
      .rd_data (ctx_rd_data)
   );

   crr_ram #(.WIDTH(CLEN_W), .DEPTH(LEN_DEPTH)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_ff),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   assign accept    = (state_ff == ST_IDLE) && req_chan.valid;
   assign tidx      = TW'(tid_ff);
   assign tid_known = int'(tid_ff) < TRANSFERS;
   // a context is open exactly when it has been written since reset
   assign c_valid   = tid_known && ctx_valid_ff[tidx];

   assign {r_exp, r_slot, r_bytes, r_full, r_ack, r_fill} = ctx_rd_data;
   assign c_exp   = c_valid ? r_exp   : '0;
   assign c_slot  = c_valid ? r_slot  : '0;
   assign c_bytes = c_valid ? r_bytes : '0;
   assign c_full  = c_valid ? r_full  : '0;
   assign c_ack   = c_valid ? r_ack   : '0;
   assign c_fill  = c_valid ? r_fill  : '0;

   assign ctx_wr_data = {w_exp_ff, w_slot_ff, w_bytes_ff, w_full_ff, w_ack_ff, w_fill_ff};

   // window position; old duplicates sit in the top WINDOW distances
   assign seq_dist = seq_ff - c_exp;
   assign in_win   = seq_dist < seq_type'(WINDOW);
   assign old_dup  = (~seq_dist) < seq_type'(WINDOW);
   assign slot_sum = {1'b0, c_slot} + SW1'(seq_dist);
   always_comb begin
      if (seq_ff >= c_exp) begin
         new_slot = (slot_sum >= SW1'(WINDOW)) ? SW'(slot_sum - SW1'(WINDOW)) : SW'(slot_sum);
      end else begin
         // crossed the 16-bit wrap, so seq is below WINDOW
         new_slot = SW'(seq_ff);
      end
   end

   assign len_wr_addr = {tidx, new_slot};

   // slot of expected+1 restarts at zero on the 16-bit wrap as well
   assign nxt_slot  = ((w_exp_ff == '1) || (w_slot_ff == SW'(WINDOW - 1))) ? '0
                                                                        : w_slot_ff + 1'b1;
   assign nxt_full  = w_full_ff & ~(WINDOW'(1) << w_slot_ff);
   assign more      = nxt_full[nxt_slot] && (k_ff < RCNT_W'(MAX_RESULTS - 1));
   assign bytes_sum = {1'b0, w_bytes_ff} + 49'(len_rd_data);
   assign bytes_sat = bytes_sum[48] ? '1 : bytes_sum[47:0];

   always_comb begin
      state_in   = state_ff;
      w_exp_in   = w_exp_ff;
      w_slot_in  = w_slot_ff;
      w_bytes_in = w_bytes_ff;
      w_full_in  = w_full_ff;
      w_ack_in   = w_ack_ff;
      w_fill_in  = w_fill_ff;
      k_in       = k_ff;
      status_in  = status_ff;
      ack_en_in  = ack_en_ff;
      wb_in      = wb_ff;
      req_chan.ready = 1'b0;
      ctx_rd_en  = 1'b0;
      ctx_wr_en  = 1'b0;
      len_wr_en  = 1'b0;
      len_rd_en  = 1'b0;
      len_rd_addr = {tidx, w_slot_ff};
      res_load   = 1'b0;
      res_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ctx_rd_en = 1'b1;
               state_in  = ST_CTX;
            end
         end

         ST_CTX: begin
            status_in = STATUS_OK;
            ack_en_in = 1'b0;
            wb_in     = 1'b0;
            state_in  = ST_ONE;
            if (cmd_ff == CMD_OPEN) begin
               if (!tid_known) begin
                  status_in = STATUS_UNKNOWN;
               end else begin
                  w_exp_in   = '0;
                  w_slot_in  = '0;
                  w_bytes_in = '0;
                  w_full_in  = '0;
                  w_ack_in   = '0;
                  w_fill_in  = '0;
                  ack_en_in  = 1'b1;
                  wb_in      = 1'b1;
               end
            end else if (len_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else if (!c_valid) begin
               status_in = STATUS_UNKNOWN;
            end else if (!in_win && !old_dup) begin
               status_in = STATUS_AHEAD;
            end else begin
               w_exp_in   = c_exp;
               w_slot_in  = c_slot;
               w_bytes_in = c_bytes;
               w_full_in  = c_full;
               if (in_win) begin
                  w_full_in = c_full | (WINDOW'(1) << new_slot);
                  len_wr_en = 1'b1;
               end
               w_ack_in  = {c_ack[31:0], seq_ff};
               w_fill_in = (c_fill < ackcnt_type'(ACK_DEPTH)) ? c_fill + 2'd1 : c_fill;
               k_in      = '0;
               ack_en_in = 1'b1;
               wb_in     = 1'b1;
               state_in  = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (w_full_ff[w_slot_ff]) begin
               len_rd_en = 1'b1;
               state_in  = ST_REL;
            end else begin
               state_in = ST_ONE;
            end
         end

         ST_REL: begin
            if (out_free) begin
               res_load                = 1'b1;
               res_data.status         = STATUS_OK;
               res_data.deliver_valid  = 1'b1;
               res_data.deliver_seq    = w_exp_ff;
               res_data.deliver_slot   = dslot_type'(w_slot_ff);
               res_data.deliver_offset = w_bytes_ff;
               res_data.deliver_length = len_rd_data;
               res_data.ack_count      = w_fill_ff;
               res_data.ack_newest     = w_ack_ff[15:0];
               res_data.ack_middle     = w_ack_ff[31:16];
               res_data.ack_oldest     = w_ack_ff[47:32];
               res_data.last           = !more;
               w_bytes_in = bytes_sat;
               w_full_in  = nxt_full;
               w_exp_in   = w_exp_ff + 16'd1;
               w_slot_in  = nxt_slot;
               k_in       = k_ff + 1'b1;
               if (more) begin
                  len_rd_en   = 1'b1;
                  len_rd_addr = {tidx, nxt_slot};
               end else begin
                  state_in = ST_WB;
               end
            end
         end

         ST_ONE: begin
            if (out_free) begin
               res_load        = 1'b1;
               res_data.status = status_ff;
               if (ack_en_ff) begin
                  res_data.ack_count  = w_fill_ff;
                  res_data.ack_newest = w_ack_ff[15:0];
                  res_data.ack_middle = w_ack_ff[31:16];
                  res_data.ack_oldest = w_ack_ff[47:32];
               end
               res_data.last = 1'b1;
               state_in = wb_ff ? ST_WB : ST_IDLE;
            end
         end

         ST_WB: begin
            ctx_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctx_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ctx_wr_en) begin
            ctx_valid_ff[tidx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.command;
         tid_ff <= req_chan.xfer_id;
         seq_ff <= req_chan.seq_id;
         len_ff <= req_chan.chunk_length;
      end
      w_exp_ff   <= w_exp_in;
      w_slot_ff  <= w_slot_in;
      w_bytes_ff <= w_bytes_in;
      w_full_ff  <= w_full_in;
      w_ack_ff   <= w_ack_in;
      w_fill_ff  <= w_fill_in;
      k_ff       <= k_in;
      status_ff  <= status_in;
      ack_en_ff  <= ack_en_in;
      wb_ff      <= wb_in;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chunk reorder receiver testbench
// Drives open and chunk words through the request channel and predicts the
// in-order release of each transfer. Every response word is checked field by
// field against the oldest predicted one. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import crr_pkg::*;

   localparam logic CMD_DATA    = 1'b1;
   localparam int   WIN         = WINDOW_DEFAULT;
   localparam int   NXFER       = TRANSFERS_DEFAULT;
   localparam int   WORD_TARGET = 410;

   // Tracks per-transfer receive state and the queue of awaited responses.
   class chunk_release_scoreboard;
      logic           open_ctx  [NXFER];
      seq_type        next_seq  [NXFER];
      offset_type     bytes_out [NXFER];
      logic           held      [NXFER][WIN];
      clen_type       held_len  [NXFER][WIN];
      logic [47:0]    ack_hist  [NXFER];
      ackcnt_type     ack_fill  [NXFER];
      crr_result_type awaited[$];
      int             errors;

      function new();
         errors = 0;
         for (int t = 0; t < NXFER; t++) begin
            clear_ctx(t);
         end
      endfunction

      function void clear_ctx(int t);
         open_ctx[t]  = 1'b0;
         next_seq[t]  = '0;
         bytes_out[t] = '0;
         ack_hist[t]  = '0;
         ack_fill[t]  = '0;
         for (int s = 0; s < WIN; s++) begin
            held[t][s]     = 1'b0;
            held_len[t][s] = '0;
         end
      endfunction

      function void queue_result(crr_result_type r);
         awaited.insert(awaited.size(), r);
      endfunction

      function string show(crr_result_type r);
         return $sformatf("st=%0d dv=%0d seq=%h slot=%0d off=%h len=%0d ack=%0d/%h/%h/%h last=%0d",
                          r.status, r.deliver_valid, r.deliver_seq, r.deliver_slot,
                          r.deliver_offset, r.deliver_length, r.ack_count, r.ack_newest,
                          r.ack_middle, r.ack_oldest, r.last);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%0t: %s", $time, msg);
         end
      endfunction

      // Predict every response caused by one accepted request word.
      function void note_word(logic cmd, tid_type tid, seq_type seq, clen_type len);
         crr_result_type r;
         seq_type        gap;
         int             n;
         int             s;
         logic [48:0]    sum;
         r      = '0;
         r.last = 1'b1;
         if (cmd == CMD_OPEN) begin
            clear_ctx(tid);
            open_ctx[tid] = 1'b1;
            queue_result(r);
            return;
         end
         if (len == 0) begin
            r.status = STATUS_EMPTY;
            queue_result(r);
            return;
         end
         if (!open_ctx[tid]) begin
            r.status = STATUS_UNKNOWN;
            queue_result(r);
            return;
         end
         gap = seq - next_seq[tid];
         if (int'(gap) < WIN) begin
            held[tid][seq % WIN]     = 1'b1;
            held_len[tid][seq % WIN] = len;
         end else if (int'(gap) < 65536 - WIN) begin
            r.status = STATUS_AHEAD;
            queue_result(r);
            return;
         end
         // in window or an old duplicate: both are acknowledged
         ack_hist[tid] = {ack_hist[tid][31:0], seq};
         if (ack_fill[tid] < ACK_DEPTH) begin
            ack_fill[tid]++;
         end
         r.ack_count  = ack_fill[tid];
         r.ack_newest = ack_hist[tid][15:0];
         r.ack_middle = ack_hist[tid][31:16];
         r.ack_oldest = ack_hist[tid][47:32];
         n = 0;
         while (n < MAX_RESULTS && held[tid][next_seq[tid] % WIN]) begin
            s = next_seq[tid] % WIN;
            r.deliver_valid  = 1'b1;
            r.deliver_seq    = next_seq[tid];
            r.deliver_slot   = dslot_type'(s);
            r.deliver_offset = bytes_out[tid];
            r.deliver_length = held_len[tid][s];
            sum = {1'b0, bytes_out[tid]} + 49'(held_len[tid][s]);
            bytes_out[tid] = sum[48] ? '1 : sum[47:0];
            held[tid][s]   = 1'b0;
            next_seq[tid]  = next_seq[tid] + 16'd1;
            n++;
            r.last = (n == MAX_RESULTS) || !held[tid][next_seq[tid] % WIN];
            queue_result(r);
         end
         if (n == 0) begin
            r.last = 1'b1;
            queue_result(r);
         end
      endfunction

      function void check_result(crr_result_type got);
         crr_result_type want;
         if (awaited.size() == 0) begin
            flag({"response with none awaited: ", show(got)});
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         if (got.status !== want.status || got.deliver_valid !== want.deliver_valid ||
             got.deliver_seq !== want.deliver_seq || got.deliver_slot !== want.deliver_slot ||
             got.deliver_offset !== want.deliver_offset ||
             got.deliver_length !== want.deliver_length ||
             got.ack_count !== want.ack_count || got.ack_newest !== want.ack_newest ||
             got.ack_middle !== want.ack_middle || got.ack_oldest !== want.ack_oldest ||
             got.last !== want.last) begin
            flag({"exp ", show(want), "\n          got ", show(got)});
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic calm;
   int   words_sent;

   chunk_release_scoreboard sb = new();
   crr_result_type seen;

   crr_req_if req_chan ();
   crr_rsp_if rsp_chan ();

   chunk_reorder_receiver_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side backpressure
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen.status         = rsp_chan.status;
         seen.deliver_valid  = rsp_chan.deliver_valid;
         seen.deliver_seq    = rsp_chan.deliver_seq;
         seen.deliver_slot   = rsp_chan.deliver_slot;
         seen.deliver_offset = rsp_chan.deliver_offset;
         seen.deliver_length = rsp_chan.deliver_length;
         seen.ack_count      = rsp_chan.ack_count;
         seen.ack_newest     = rsp_chan.ack_newest;
         seen.ack_middle     = rsp_chan.ack_middle;
         seen.ack_oldest     = rsp_chan.ack_oldest;
         seen.last           = rsp_chan.last;
         sb.check_result(seen);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(logic cmd, tid_type tid, seq_type seq, clen_type len);
      while (!calm && $urandom_range(99) < 13) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.xfer_id      <= tid;
      req_chan.seq_id       <= seq;
      req_chan.chunk_length <= len;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      sb.note_word(cmd, tid, seq, len);
      words_sent++;
      @(negedge clock);
   endtask

   // stray words: empty, far ahead, stale duplicate, window edge, open
   task automatic send_noise();
      tid_type t;
      int      pick;
      t    = tid_type'($urandom_range(NXFER - 1));
      pick = $urandom_range(4);
      case (pick)
         0: send_word(CMD_DATA, t, seq_type'($urandom), '0);
         1: send_word(CMD_DATA, t, seq_type'($urandom), clen_type'($urandom_range(1, 511)));
         2: send_word(CMD_DATA, t, sb.next_seq[t] - 16'd1 - seq_type'($urandom_range(WIN - 1)),
                      clen_type'($urandom_range(1, 511)));
         3: send_word(CMD_DATA, t, sb.next_seq[t] + seq_type'(WIN - 1 + $urandom_range(1)),
                      clen_type'($urandom_range(1, 511)));
         default: send_word(CMD_OPEN, t, seq_type'($urandom), clen_type'($urandom));
      endcase
   endtask

   // Each burst delivers a run of consecutive chunks in shuffled order, often
   // holding the head chunk back so the whole run releases at once.
   task automatic send_bursts();
      seq_type order [WIN];
      seq_type base;
      seq_type tmp;
      tid_type tid;
      int      k;
      int      pick;
      while (words_sent < WORD_TARGET) begin
         calm = (words_sent >= 180 && words_sent < 270);
         tid  = tid_type'($urandom_range(NXFER - 1));
         if (!sb.open_ctx[tid] || $urandom_range(19) == 0) begin
            send_word(CMD_OPEN, tid, seq_type'($urandom), clen_type'($urandom));
         end
         k    = ($urandom_range(3) == 0) ? WIN : $urandom_range(1, WIN);
         base = sb.next_seq[tid];
         for (int j = 0; j < k; j++) begin
            order[j] = base + seq_type'(j);
         end
         for (int j = k - 1; j > 0; j--) begin
            pick     = $urandom_range(j);
            tmp      = order[j];
            order[j] = order[pick];
            order[pick] = tmp;
         end
         if ($urandom_range(1) == 1) begin
            for (int j = 0; j < k; j++) begin
               if (order[j] == base) begin
                  order[j]     = order[k - 1];
                  order[k - 1] = base;
               end
            end
         end
         for (int j = 0; j < k; j++) begin
            if ($urandom_range(99) < 15) begin
               send_noise();
            end
            send_word(CMD_DATA, tid, order[j],
                      ($urandom_range(9) == 0) ? clen_type'(511)
                                               : clen_type'($urandom_range(1, 511)));
            if ($urandom_range(19) == 0) begin
               send_word(CMD_DATA, tid, order[j], clen_type'($urandom_range(1, 511)));
            end
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      calm                  <= 1'b0;
      words_sent             = 0;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_OPEN;
      req_chan.xfer_id      <= '0;
      req_chan.seq_id       <= '0;
      req_chan.chunk_length <= '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(CMD_DATA, 3'd3, 16'd0, 9'd5);          // transfer never opened
      send_word(CMD_OPEN, 3'd0, 16'hFFFF, 9'd511);
      send_word(CMD_DATA, 3'd0, 16'd0, 9'd0);          // empty chunk
      send_word(CMD_DATA, 3'd0, 16'd0, 9'd511);
      send_word(CMD_DATA, 3'd0, 16'd2, 9'd1);
      send_word(CMD_DATA, 3'd0, 16'd3, 9'd100);
      send_word(CMD_DATA, 3'd0, 16'd3, 9'd200);        // overwrite held chunk
      send_word(CMD_DATA, 3'd0, 16'd1, 9'd300);        // gap fill releases three
      send_word(CMD_DATA, 3'd0, 16'd20, 9'd7);         // one past the window
      send_word(CMD_DATA, 3'd0, 16'd19, 9'd7);         // last slot of the window
      send_word(CMD_DATA, 3'd0, 16'd2, 9'd9);          // stale duplicate
      send_word(CMD_DATA, 3'd0, 16'hFFF4, 9'd9);       // oldest duplicate still acked
      send_word(CMD_DATA, 3'd0, 16'hFFF3, 9'd9);       // just beyond that: dropped
      send_word(CMD_DATA, 3'd0, 16'hAAAA, 9'd255);
      send_word(CMD_OPEN, 3'd7, 16'd0, 9'd0);
      send_word(CMD_DATA, 3'd7, 16'h5555, 9'd256);
      send_word(CMD_DATA, 3'd7, 16'd0, 9'd1);
      send_word(CMD_OPEN, 3'd0, 16'd0, 9'd0);          // reopen drops held slots
      send_word(CMD_DATA, 3'd0, 16'd3, 9'd2);
      send_word(CMD_DATA, 3'd0, 16'd0, 9'd4);

      send_bursts();
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (sb.awaited.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
